>>> rtl/core/fsrq_pkg.sv
// Shared types, constants and codes of the fair-share run queue.
`timescale 1ns / 1ps
package fsrq_pkg;

    localparam int TASK_W  = 4;
    localparam int OP_W    = 3;
    localparam int PRIO_W  = 7;
    localparam int DELTA_W = 32;
    localparam int RT_W    = 64;
    localparam int CFG_W   = 20;
    localparam int STAT_W  = 2;
    localparam int QCNT_W  = 5;
    localparam int CIDX_W  = 2;

    localparam int DEF_MAX_TASKS = 16;

    localparam logic [CFG_W-1:0] LATENCY_RST = 20'd10000;
    localparam logic [CFG_W-1:0] GRAN_RST    = 20'd1000;
    localparam logic [CFG_W-1:0] TICK_RST    = 20'd1000;

    localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
    localparam logic [OP_W-1:0] OP_ENQUEUE  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEQUEUE  = 3'd2;
    localparam logic [OP_W-1:0] OP_PICK     = 3'd3;
    localparam logic [OP_W-1:0] OP_CHARGE   = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_QUEUED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN    = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_LATENCY = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GRAN    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TICK    = 2'd2;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_REMOVE,
        CMD_INSERT
    } cmd_op_t;

    typedef struct packed {
        logic              valid;
        logic [TASK_W-1:0] id;
        logic [RT_W-1:0]   key;
    } cell_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [TASK_W-1:0] id;
        logic [RT_W-1:0]   key;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_UPD,
        S_TSTART,
        S_TWAIT,
        S_DECIDE,
        S_REMOVE,
        S_INSERT,
        S_FSTART,
        S_FWAIT,
        S_DONE
    } state_t;

endpackage

>>> rtl/core/fsrq_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module fsrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fsrq_cell.sv
// One cell of the sorted run-queue chain: holds one queued task and its key.
`timescale 1ns / 1ps
module fsrq_cell
    import fsrq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  cell_t left,
    input  cell_t right,
    input  logic  match_in,
    input  logic  le_in,
    output cell_t own,
    output logic  match_out,
    output logic  le_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [TASK_W-1:0] id_reg;
    logic [TASK_W-1:0] id_next;
    logic [RT_W-1:0]   key_reg;
    logic [RT_W-1:0]   key_next;

    assign own.valid = valid_reg;
    assign own.id    = id_reg;
    assign own.key   = key_reg;

    assign match_out = match_in || (valid_reg && (id_reg == cmd.id));
    assign le_out    = valid_reg && (key_reg <= cmd.key);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        key_next   = key_reg;
        case (cmd.op)
            CMD_REMOVE:
            begin
                if (match_out)
                begin
                    valid_next = right.valid;
                    id_next    = right.id;
                    key_next   = right.key;
                end
            end
            CMD_INSERT:
            begin
                if (!le_out)
                begin
                    if (le_in)
                    begin
                        valid_next = 1'b1;
                        id_next    = cmd.id;
                        key_next   = cmd.key;
                    end
                    else
                    begin
                        valid_next = left.valid;
                        id_next    = left.id;
                        key_next   = left.key;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

endmodule

>>> rtl/core/fsrq_div.sv
// Restoring divider, one quotient bit per cycle, for the slice computation.
`timescale 1ns / 1ps
module fsrq_div
    import fsrq_pkg::*;
#(
    parameter int DIVW = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CFG_W-1:0] dividend,
    input  logic [DIVW-1:0]  divisor,
    output logic             done,
    output logic [CFG_W-1:0] quotient
);

    localparam int STEP_W = $clog2(CFG_W + 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [DIVW-1:0]   rem_reg;
    logic [DIVW-1:0]   rem_next;
    logic [DIVW-1:0]   div_reg;
    logic [DIVW-1:0]   div_next;
    logic [CFG_W-1:0]  quo_reg;
    logic [CFG_W-1:0]  quo_next;
    logic [DIVW:0]     trial;
    logic [DIVW:0]     diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[CFG_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIVW-1:0] : trial[DIVW-1:0];
            quo_next  = {quo_reg[CFG_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CFG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/fair_share_run_queue.sv
// Top level of the fair-share run queue: sequencer, task store, cell chain and divider.
// Each slice computation runs the 20-step serial divider; a tick needs it twice.
// One item at a time: in_stall stays high until the last item's result is loaded into the output registers.
// Reset clears the queue, the task-known flags, the floor and restores the default registers.
`timescale 1ns / 1ps
module fair_share_run_queue
    import fsrq_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [TASK_W-1:0] task_id,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [DELTA_W-1:0] charge_us,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [TASK_W-1:0] chosen_task,
    output logic              preempt,
    output logic [CFG_W-1:0]  slice_us,
    output logic [QCNT_W-1:0] queued_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int AW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int RAM_W = PRIO_W + RT_W;

    state_t state_reg;
    state_t state_next;

    logic [CFG_W-1:0] latency_reg;
    logic [CFG_W-1:0] gran_reg;
    logic [CFG_W-1:0] tick_reg;

    logic [OP_W-1:0]   op_reg;
    logic [TASK_W-1:0] id_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [DELTA_W-1:0] delta_reg;

    logic [MAX_TASKS-1:0] known_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [RT_W-1:0]      floor_reg;

    logic [STAT_W-1:0] stat_reg;
    logic [STAT_W-1:0] stat_next;
    logic [TASK_W-1:0] chosen_reg;
    logic [TASK_W-1:0] chosen_next;
    logic              rm_reg;
    logic              rm_next;
    logic              ins_reg;
    logic              ins_next;
    logic              wr_reg;
    logic              wr_next;
    logic              istick_reg;
    logic              istick_next;
    logic              pre_reg;
    logic              pre_next;
    logic [RT_W-1:0]   rt_reg;
    logic [RT_W-1:0]   rt_next;
    logic [PRIO_W-1:0] wprio_reg;
    logic [PRIO_W-1:0] wprio_next;
    logic [CFG_W-1:0]  slice_t_reg;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_stat_reg;
    logic [TASK_W-1:0] out_chosen_reg;
    logic              out_pre_reg;
    logic [CFG_W-1:0]  out_slice_reg;
    logic [QCNT_W-1:0] out_count_reg;

    logic              accept;
    logic              out_take;
    logic              can_load;
    logic [AW+TASK_W-1:0] in_ext;
    logic [AW+TASK_W-1:0] id_ext;
    logic [AW-1:0]     in_addr;
    logic [AW-1:0]     id_addr;
    logic              id_ok;
    logic              known;
    logic [RAM_W-1:0]  ram_rdata;
    logic [RT_W-1:0]   ram_rt;
    logic [PRIO_W-1:0] ram_prio;
    logic [3:0]        shamt;
    logic [DELTA_W-1:0] charge_amt;
    logic [RT_W-1:0]   charged;
    logic [RT_W-1:0]   gap;
    logic              hit;

    cmd_t              cmd;
    cell_t             cells [MAX_TASKS];
    logic [MAX_TASKS:0] match_ch;
    logic [MAX_TASKS:0] le_ch;
    logic [MAX_TASKS-1:0] valid_vec;

    logic              div_start;
    logic              div_done;
    logic [CW-1:0]     divisor;
    logic [CFG_W-1:0]  quotient;
    logic [CFG_W-1:0]  slice_w;
    logic [CW+QCNT_W-1:0] count_ext;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_take  = out_valid_reg && !out_stall;
    assign can_load  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign in_ext  = {{AW{1'b0}}, task_id};
    assign id_ext  = {{AW{1'b0}}, id_reg};
    assign in_addr = in_ext[AW-1:0];
    assign id_addr = id_ext[AW-1:0];
    assign id_ok   = (32'(id_reg) < MAX_TASKS);
    assign known   = id_ok && known_reg[id_addr];

    fsrq_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_TASKS)
    ) u_store (
        .clk  (clk),
        .we   (state_reg == S_UPD && wr_reg),
        .waddr(id_addr),
        .wdata({wprio_reg, rt_reg}),
        .re   (accept),
        .raddr(in_addr),
        .rdata(ram_rdata)
    );

    assign ram_rt   = ram_rdata[RT_W-1:0];
    assign ram_prio = ram_rdata[RAM_W-1:RT_W];
    assign shamt    = ram_prio[PRIO_W-1:3];
    assign charge_amt = (op_reg == OP_TICK) ? DELTA_W'(tick_reg) : delta_reg;
    assign charged  = ram_rt + ({{(RT_W-DELTA_W){1'b0}}, charge_amt} << shamt);
    assign gap      = rt_reg - floor_reg;

    assign match_ch[0] = 1'b0;
    assign le_ch[0]    = 1'b1;

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        cell_t left_c;
        cell_t right_c;
        if (i == 0)
        begin : g_first
            assign left_c = '0;
        end
        else
        begin : g_mid
            assign left_c = cells[i-1];
        end
        if (i == MAX_TASKS - 1)
        begin : g_last
            assign right_c = '0;
        end
        else
        begin : g_inner
            assign right_c = cells[i+1];
        end
        fsrq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .left     (left_c),
            .right    (right_c),
            .match_in (match_ch[i]),
            .le_in    (le_ch[i]),
            .own      (cells[i]),
            .match_out(match_ch[i+1]),
            .le_out   (le_ch[i+1])
        );
        assign valid_vec[i] = cells[i].valid;
    end

    assign hit = match_ch[MAX_TASKS];

    assign divisor = (count_reg == '0) ? CW'(1) : count_reg;

    fsrq_div #(
        .DIVW(CW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(latency_reg),
        .divisor (divisor),
        .done    (div_done),
        .quotient(quotient)
    );

    assign slice_w   = (quotient < gran_reg) ? gran_reg : quotient;
    assign count_ext = {{QCNT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_EXEC;
            S_EXEC:   state_next = S_UPD;
            S_UPD:    state_next = istick_reg ? S_TSTART : S_REMOVE;
            S_TSTART: state_next = S_TWAIT;
            S_TWAIT:  if (div_done) state_next = S_DECIDE;
            S_DECIDE: state_next = S_REMOVE;
            S_REMOVE: state_next = S_INSERT;
            S_INSERT: state_next = S_FSTART;
            S_FSTART: state_next = S_FWAIT;
            S_FWAIT:  if (div_done) state_next = S_DONE;
            S_DONE:   if (can_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = CMD_NONE;
        cmd.id    = id_reg;
        cmd.key   = rt_reg;
        div_start = 1'b0;
        case (state_reg)
            S_REMOVE: if (rm_reg) cmd.op = CMD_REMOVE;
            S_INSERT: if (ins_reg) cmd.op = CMD_INSERT;
            S_TSTART: div_start = 1'b1;
            S_FSTART: div_start = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat_next   = stat_reg;
        chosen_next = chosen_reg;
        rm_next     = rm_reg;
        ins_next    = ins_reg;
        wr_next     = wr_reg;
        istick_next = istick_reg;
        pre_next    = pre_reg;
        rt_next     = rt_reg;
        wprio_next  = wprio_reg;
        count_next  = count_reg;
        if (state_reg == S_EXEC)
        begin
            stat_next   = STAT_OK;
            chosen_next = '0;
            rm_next     = 1'b0;
            ins_next    = 1'b0;
            wr_next     = 1'b0;
            istick_next = 1'b0;
            pre_next    = 1'b0;
            rt_next     = ram_rt;
            wprio_next  = ram_prio;
            case (op_reg)
                OP_REGISTER:
                begin
                    if (!id_ok)
                    begin
                        stat_next = STAT_UNKNOWN;
                    end
                    else
                    begin
                        rt_next    = floor_reg;
                        wprio_next = prio_reg;
                        wr_next    = 1'b1;
                        rm_next    = hit;
                        ins_next   = hit;
                    end
                end
                OP_ENQUEUE:
                begin
                    if (!known)
                    begin
                        stat_next = STAT_UNKNOWN;
                    end
                    else
                    begin
                        rm_next  = hit;
                        ins_next = 1'b1;
                    end
                end
                OP_DEQUEUE:
                begin
                    if (!known)
                    begin
                        stat_next = STAT_UNKNOWN;
                    end
                    else if (!hit)
                    begin
                        stat_next = STAT_NOT_QUEUED;
                    end
                    else
                    begin
                        rm_next = 1'b1;
                    end
                end
                OP_PICK:
                begin
                    if (count_reg == '0)
                    begin
                        stat_next = STAT_EMPTY;
                    end
                    else
                    begin
                        chosen_next = cells[0].id;
                    end
                end
                OP_CHARGE, OP_TICK:
                begin
                    if (!known)
                    begin
                        stat_next = STAT_UNKNOWN;
                    end
                    else
                    begin
                        rt_next     = charged;
                        wr_next     = 1'b1;
                        rm_next     = hit;
                        ins_next    = hit;
                        istick_next = (op_reg == OP_TICK);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_DECIDE)
        begin
            if (gap > {{(RT_W-CFG_W){1'b0}}, slice_t_reg})
            begin
                pre_next = 1'b1;
                ins_next = 1'b1;
            end
        end
        else if (state_reg == S_REMOVE && rm_reg)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (state_reg == S_INSERT && ins_reg)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            latency_reg   <= LATENCY_RST;
            gran_reg      <= GRAN_RST;
            tick_reg      <= TICK_RST;
            known_reg     <= '0;
            count_reg     <= '0;
            floor_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LATENCY: latency_reg <= cfg_data;
                    CFG_GRAN:    gran_reg    <= cfg_data;
                    CFG_TICK:    tick_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_UPD && wr_reg)
            begin
                known_reg[id_addr] <= 1'b1;
                if (rt_reg > floor_reg)
                begin
                    floor_reg <= rt_reg;
                end
            end
            if (state_reg == S_DONE && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            id_reg    <= task_id;
            prio_reg  <= priority_req;
            delta_reg <= charge_us;
        end
        stat_reg   <= stat_next;
        chosen_reg <= chosen_next;
        rm_reg     <= rm_next;
        ins_reg    <= ins_next;
        wr_reg     <= wr_next;
        istick_reg <= istick_next;
        pre_reg    <= pre_next;
        rt_reg     <= rt_next;
        wprio_reg  <= wprio_next;
        if (state_reg == S_TWAIT && div_done)
        begin
            slice_t_reg <= slice_w;
        end
        if (state_reg == S_DONE && can_load)
        begin
            out_stat_reg   <= stat_reg;
            out_chosen_reg <= chosen_reg;
            out_pre_reg    <= pre_reg;
            out_slice_reg  <= slice_w;
            out_count_reg  <= count_ext[QCNT_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_stat_reg;
    assign chosen_task  = out_chosen_reg;
    assign preempt      = out_pre_reg;
    assign slice_us     = out_slice_reg;
    assign queued_count = out_count_reg;

    // The occupied cells always form a prefix; the check here is that their number equals the queue length.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("cell occupancy does not match queue length");

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_TASKS)
        else $error("queue length exceeds capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not start execution");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the completion step");

endmodule

>>> dv/tb_fair_share_run_queue.sv
// Self-checking testbench of the fair-share run queue with a predictor, a driver and a monitor.
`timescale 1ns / 1ps
module tb_fair_share_run_queue;
    import fsrq_pkg::*;

    localparam int NTASK = 16;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TASK_W-1:0]  tid;
        logic [PRIO_W-1:0]  prio;
        logic [DELTA_W-1:0] delta;
    } sched_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TASK_W-1:0] chosen;
        logic              preempt;
        logic [CFG_W-1:0]  slice;
        logic [QCNT_W-1:0] count;
    } sched_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_W-1:0] op = '0;
    logic [TASK_W-1:0] task_id = '0;
    logic [PRIO_W-1:0] priority_req = '0;
    logic [DELTA_W-1:0] charge_us = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [TASK_W-1:0] chosen_task;
    logic preempt;
    logic [CFG_W-1:0] slice_us;
    logic [QCNT_W-1:0] queued_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    fair_share_run_queue u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .task_id(task_id), .priority_req(priority_req), .charge_us(charge_us),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .chosen_task(chosen_task), .preempt(preempt),
        .slice_us(slice_us), .queued_count(queued_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    logic [CFG_W-1:0] m_latency = LATENCY_RST;
    logic [CFG_W-1:0] m_gran = GRAN_RST;
    logic [CFG_W-1:0] m_tick = TICK_RST;
    logic [RT_W-1:0] m_runtime [NTASK];
    logic [PRIO_W-1:0] m_prio [NTASK];
    bit m_known [NTASK];
    int m_order [$];
    logic [RT_W-1:0] m_floor = '0;

    sched_req_t pending_reqs [$];
    sched_rsp_t expected_rsps [$];
    int mismatches = 0;
    int results_seen = 0;
    int preempts_seen = 0;
    int cycles = 0;
    int stall_left = 0;
    bit hold_sender = 1'b0;
    bit cfg_busy = 1'b0;
    bit in_taken = 1'b0;

    function automatic int find_task(int t);
        foreach (m_order[i])
            if (m_order[i] == t)
                return i;
        return -1;
    endfunction

    function automatic void requeue_task(int t);
        int p;
        p = find_task(t);
        if (p >= 0)
            m_order.delete(p);
        p = 0;
        while (p < m_order.size() && m_runtime[m_order[p]] <= m_runtime[t])
            p++;
        m_order.insert(p, t);
    endfunction

    function automatic void charge_task(int t, logic [RT_W-1:0] d);
        m_runtime[t] = m_runtime[t] + (d << (m_prio[t] >> 3));
        if (m_runtime[t] > m_floor)
            m_floor = m_runtime[t];
        if (find_task(t) >= 0)
            requeue_task(t);
    endfunction

    function automatic logic [CFG_W-1:0] current_slice();
        logic [CFG_W-1:0] s;
        int n;
        n = (m_order.size() == 0) ? 1 : m_order.size();
        s = CFG_W'(m_latency / n);
        if (s < m_gran)
            s = m_gran;
        return s;
    endfunction

    function automatic sched_rsp_t schedule_step(sched_req_t r);
        sched_rsp_t o;
        int t;
        int p;
        o = '0;
        t = r.tid;
        if (r.op <= OP_TICK && r.op != OP_PICK && r.op != OP_REGISTER && !m_known[t]) begin
            o.status = STAT_UNKNOWN;
        end else begin
            case (r.op)
                OP_REGISTER:
                begin
                    m_prio[t] = r.prio;
                    m_runtime[t] = m_floor;
                    m_known[t] = 1'b1;
                    if (find_task(t) >= 0)
                        requeue_task(t);
                end
                OP_ENQUEUE: requeue_task(t);
                OP_DEQUEUE:
                begin
                    p = find_task(t);
                    if (p < 0)
                        o.status = STAT_NOT_QUEUED;
                    else
                        m_order.delete(p);
                end
                OP_PICK:
                begin
                    if (m_order.size() == 0)
                        o.status = STAT_EMPTY;
                    else
                        o.chosen = TASK_W'(m_order[0]);
                end
                OP_CHARGE: charge_task(t, {32'd0, r.delta});
                OP_TICK:
                begin
                    charge_task(t, {44'd0, m_tick});
                    if (m_runtime[t] - m_floor > {44'd0, current_slice()}) begin
                        requeue_task(t);
                        o.preempt = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        o.slice = current_slice();
        o.count = QCNT_W'(m_order.size());
        return o;
    endfunction

    // The payload may only change once the item on the port has been taken.
    always @(negedge clk)
    begin
        if (!in_valid || in_taken) begin
            in_taken = 1'b0;
            if (pending_reqs.size() > 0 && !hold_sender && !cfg_busy
                && ($urandom_range(0, 3) != 0)) begin
                in_valid <= 1'b1;
                op <= pending_reqs[0].op;
                task_id <= pending_reqs[0].tid;
                priority_req <= pending_reqs[0].prio;
                charge_us <= pending_reqs[0].delta;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall) begin
            expected_rsps.push_back(schedule_step(pending_reqs.pop_front()));
            in_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= ($urandom_range(0, 7) < ((cycles / 3000) % 4));
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result at cycle %0d", cycles);
            end else if ({status, chosen_task, preempt, slice_us, queued_count}
                         !== expected_rsps[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp st=%0d ch=%0d pre=%0d sl=%0d n=%0d got %0d %0d %0d %0d %0d",
                             expected_rsps[0].status, expected_rsps[0].chosen,
                             expected_rsps[0].preempt, expected_rsps[0].slice,
                             expected_rsps[0].count, status, chosen_task, preempt,
                             slice_us, queued_count);
                void'(expected_rsps.pop_front());
            end else begin
                if (preempt)
                    preempts_seen++;
                void'(expected_rsps.pop_front());
            end
            results_seen++;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic add_req(logic [OP_W-1:0] o, int t, int p, logic [DELTA_W-1:0] d);
        sched_req_t r;
        r.op = o;
        r.tid = TASK_W'(t);
        r.prio = PRIO_W'(p);
        r.delta = d;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_busy = 1'b1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LATENCY: m_latency = val;
            CFG_GRAN: m_gran = val;
            CFG_TICK: m_tick = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_busy = 1'b0;
    endtask

    task automatic random_batch(int n, int nt);
        int k;
        int pick;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                add_req(OP_REGISTER, $urandom_range(0, nt), $urandom_range(0, 127), $urandom);
            else if (pick < 30)
                add_req(OP_ENQUEUE, $urandom_range(0, nt), $urandom, $urandom);
            else if (pick < 40)
                add_req(OP_DEQUEUE, $urandom_range(0, nt), $urandom, $urandom);
            else if (pick < 52)
                add_req(OP_PICK, $urandom, $urandom, $urandom);
            else if (pick < 68)
                add_req(OP_CHARGE, $urandom_range(0, nt), $urandom,
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000));
            else if (pick < 97)
                add_req(OP_TICK, $urandom_range(0, nt), $urandom, $urandom);
            else
                add_req(OP_W'($urandom_range(6, 7)), $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < NTASK; i++) begin
            m_runtime[i] = '0;
            m_prio[i] = '0;
            m_known[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_req(OP_PICK, 0, 0, 0);
        add_req(OP_ENQUEUE, 3, 0, 0);
        add_req(OP_DEQUEUE, 3, 0, 0);
        add_req(OP_CHARGE, 15, 0, 32'hFFFFFFFF);
        add_req(OP_TICK, 7, 0, 0);
        add_req(OP_REGISTER, 0, 0, 0);
        add_req(OP_REGISTER, 15, 127, 32'hFFFFFFFF);
        add_req(OP_REGISTER, 5, 79, 0);
        add_req(OP_DEQUEUE, 5, 0, 0);
        add_req(OP_ENQUEUE, 0, 0, 0);
        add_req(OP_ENQUEUE, 15, 0, 0);
        add_req(OP_ENQUEUE, 5, 0, 0);
        add_req(OP_ENQUEUE, 0, 0, 0);
        add_req(OP_PICK, 0, 0, 0);
        add_req(OP_CHARGE, 15, 0, 32'hFFFFFFFF);
        add_req(OP_CHARGE, 15, 0, 32'hFFFFFFFF);
        add_req(OP_TICK, 0, 0, 0);
        add_req(OP_TICK, 5, 0, 0);
        add_req(OP_REGISTER, 0, 8, 0);
        add_req(OP_PICK, 0, 0, 0);
        add_req(3'd6, 2, 0, 0);
        add_req(3'd7, 9, 127, 32'hFFFFFFFF);
        add_req(OP_DEQUEUE, 15, 0, 0);
        add_req(OP_PICK, 0, 0, 0);
        drain();

        write_cfg(CFG_LATENCY, 20'hFFFFF);
        write_cfg(CFG_GRAN, 20'd1);
        write_cfg(CFG_TICK, 20'd0);
        random_batch(150, 15);
        drain();

        write_cfg(CFG_LATENCY, 20'd0);
        write_cfg(CFG_GRAN, 20'd0);
        write_cfg(CFG_TICK, 20'hFFFFF);
        random_batch(150, 15);
        drain();

        write_cfg(CFG_LATENCY, 20'd40000);
        write_cfg(CFG_GRAN, 20'd500);
        write_cfg(CFG_TICK, 20'd1500);
        for (i = 0; i < 16; i++)
            add_req(OP_REGISTER, i, $urandom_range(0, 79), 0);
        for (i = 0; i < 16; i++)
            add_req(OP_ENQUEUE, i, 0, 0);
        stall_left = 3000;
        random_batch(40, 15);
        while (stall_left > 0)
            @(posedge clk);
        hold_sender = 1'b1;
        while (expected_rsps.size() > 0 || in_valid)
            @(posedge clk);
        hold_sender = 1'b0;
        random_batch(200, 15);
        drain();

        write_cfg(CFG_LATENCY, $urandom_range(1, 20'hFFFFF));
        write_cfg(CFG_GRAN, $urandom_range(1, 20000));
        write_cfg(CFG_TICK, $urandom_range(0, 5000));
        random_batch(230, 15);
        drain();

        $display("Covered %0d results, %0d preemptions, five register settings.",
                 results_seen, preempts_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
